// ===== hw/rtl/ptb_pkg.sv =====
`timescale 1ns / 1ps

package ptb_pkg;

   localparam int OP_W      = 2;
   localparam int CLIENT_W  = 8;
   localparam int TIME_W    = 32;
   localparam int RATE_W    = 32;
   localparam int TOKEN_W   = 40;
   localparam int COUNT_W   = 32;
   localparam int ACTIVE_W  = 9;
   localparam int PROD_W    = TIME_W + RATE_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int FRAC_BITS = 24;

   localparam int CLIENT_SPAN = 1 << CLIENT_W;

   localparam int REQ_DATA_W = CLIENT_W + TIME_W;
   localparam int RSP_USED_W = 1 + TOKEN_W + 1 + 3 * COUNT_W + ACTIVE_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;

   localparam logic [TOKEN_W-1:0] ONE_TOKEN = TOKEN_W'(1) << FRAC_BITS;

   localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd1;
   localparam logic [OP_W-1:0] OP_RESET   = 2'd2;

   localparam logic REG_RATE     = 1'b0;
   localparam logic REG_CAPACITY = 1'b1;

   localparam logic [RATE_W-1:0]  RATE_RESET     = 32'd1678;
   localparam logic [TOKEN_W-1:0] CAPACITY_RESET = 40'd3355443200;

   typedef struct packed {
      logic load;
      logic mul;
      logic refill;
      logic commit;
   } ctl_cmd_type;

endpackage

// ===== hw/rtl/ptb_csr.sv =====
`timescale 1ns / 1ps

module ptb_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ptb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ptb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ptb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output logic [ptb_pkg::RATE_W-1:0]         refill_rate,
   output logic [ptb_pkg::TOKEN_W-1:0]        bucket_capacity
);

   logic [ptb_pkg::RATE_W-1:0]  rate_ff, rate_in;
   logic [ptb_pkg::TOKEN_W-1:0] cap_ff, cap_in;
   logic                        wr_en;
   logic                        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[ptb_pkg::CSR_ADDR_W-1];

   always_comb begin
      rate_in = rate_ff;
      cap_in  = cap_ff;
      if (wr_en) begin
         case (reg_sel)
            ptb_pkg::REG_RATE:     rate_in = csr_pwdata[ptb_pkg::RATE_W-1:0];
            ptb_pkg::REG_CAPACITY: cap_in  = csr_pwdata[ptb_pkg::TOKEN_W-1:0];
            default:               rate_in = rate_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         ptb_pkg::REG_RATE:     csr_prdata = ptb_pkg::CSR_DATA_W'(rate_ff);
         ptb_pkg::REG_CAPACITY: csr_prdata = ptb_pkg::CSR_DATA_W'(cap_ff);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= ptb_pkg::RATE_RESET;
         cap_ff  <= ptb_pkg::CAPACITY_RESET;
      end else begin
         rate_ff <= rate_in;
         cap_ff  <= cap_in;
      end
   end

   assign refill_rate     = rate_ff;
   assign bucket_capacity = cap_ff;

endmodule

// ===== hw/rtl/ptb_ctrl.sv =====
`timescale 1ns / 1ps

module ptb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output ptb_pkg::ctl_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MUL    = 2'd1;
   localparam logic [1:0] ST_REFILL = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.load   = req_tvalid & req_tready;
      cmd.mul    = (state_ff == ST_MUL);
      cmd.refill = (state_ff == ST_REFILL);
      cmd.commit = (state_ff == ST_UPDATE) & (~rsp_valid_ff | rsp_tready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (cmd.load)   state_in = ST_MUL;
         ST_MUL:    state_in = ST_REFILL;
         ST_REFILL: state_in = ST_UPDATE;
         ST_UPDATE: if (cmd.commit) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/ptb_dpath.sv =====
`timescale 1ns / 1ps

module ptb_dpath #(
   parameter int MAX_CLIENTS = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ptb_pkg::ctl_cmd_type               cmd,
   input  logic [ptb_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [ptb_pkg::OP_W-1:0]           req_tuser,
   input  logic [ptb_pkg::RATE_W-1:0]         refill_rate,
   input  logic [ptb_pkg::TOKEN_W-1:0]        bucket_capacity,
   output logic [ptb_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int DEPTH = (MAX_CLIENTS < ptb_pkg::CLIENT_SPAN) ? MAX_CLIENTS
                                                               : ptb_pkg::CLIENT_SPAN;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LIM_W = 17;
   localparam logic [LIM_W-1:0] CLIENT_LIMIT = LIM_W'(MAX_CLIENTS);
   localparam int ENTRY_W = ptb_pkg::TOKEN_W + ptb_pkg::TIME_W;

   logic [ptb_pkg::CLIENT_W-1:0] req_client;
   logic [ptb_pkg::TIME_W-1:0]   req_now;
   logic                         req_inrange;
   logic [IDX_W-1:0]             req_idx;

   logic [ENTRY_W-1:0]           mem [DEPTH];
   logic [DEPTH-1:0]             valid_ff;

   logic [ptb_pkg::OP_W-1:0]     op_ff;
   logic [IDX_W-1:0]             idx_ff;
   logic [ptb_pkg::TIME_W-1:0]   now_ff;
   logic                         inrange_ff;
   logic                         known_ff;
   logic [ptb_pkg::TOKEN_W-1:0]  rd_tokens_ff;
   logic [ptb_pkg::TIME_W-1:0]   rd_stamp_ff;
   logic [ptb_pkg::PROD_W-1:0]   product_ff;
   logic [ptb_pkg::TOKEN_W-1:0]  refill_ff, refill_in;

   logic [ptb_pkg::COUNT_W-1:0]  seen_ff, seen_in;
   logic [ptb_pkg::COUNT_W-1:0]  granted_ff, granted_in;
   logic [ptb_pkg::COUNT_W-1:0]  denied_ff, denied_in;
   logic [ptb_pkg::ACTIVE_W-1:0] active_ff, active_in;
   logic [ptb_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [ptb_pkg::TIME_W-1:0]   elapsed;
   logic [ptb_pkg::SUM_W-1:0]    sum;
   logic [ptb_pkg::TOKEN_W-1:0]  debit;
   logic                         grant_ok;

   logic                         allowed;
   logic [ptb_pkg::TOKEN_W-1:0]  tokens;
   logic                         wr_en;
   logic                         set_valid;
   logic                         seen_inc;
   logic                         grant_inc;
   logic                         deny_inc;

   assign req_client  = req_tdata[ptb_pkg::CLIENT_W-1:0];
   assign req_now     = req_tdata[ptb_pkg::REQ_DATA_W-1:ptb_pkg::CLIENT_W];
   assign req_inrange = (LIM_W'(req_client) < CLIENT_LIMIT);
   assign req_idx     = req_client[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff                       <= req_tuser;
         idx_ff                      <= req_idx;
         now_ff                      <= req_now;
         inrange_ff                  <= req_inrange;
         known_ff                    <= req_inrange && valid_ff[req_idx];
         {rd_tokens_ff, rd_stamp_ff} <= mem[req_idx];
      end
      if (cmd.commit && wr_en) begin
         mem[idx_ff] <= {tokens, now_ff};
      end
   end

   assign elapsed = now_ff - rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         product_ff <= ptb_pkg::PROD_W'(elapsed) * ptb_pkg::PROD_W'(refill_rate);
      end
   end

   assign sum = ptb_pkg::SUM_W'(rd_tokens_ff) + ptb_pkg::SUM_W'(product_ff);

   always_comb begin
      if (rd_tokens_ff >= bucket_capacity || sum >= ptb_pkg::SUM_W'(bucket_capacity)) begin
         refill_in = bucket_capacity;
      end else begin
         refill_in = sum[ptb_pkg::TOKEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.refill) begin
         refill_ff <= refill_in;
      end
   end

   assign grant_ok = (refill_ff >= ptb_pkg::ONE_TOKEN);
   assign debit    = refill_ff - ptb_pkg::ONE_TOKEN;

   always_comb begin
      allowed   = 1'b0;
      tokens    = bucket_capacity;
      wr_en     = 1'b0;
      set_valid = 1'b0;
      seen_inc  = 1'b0;
      grant_inc = 1'b0;
      deny_inc  = 1'b0;
      case (op_ff)
         ptb_pkg::OP_REQUEST: begin
            seen_inc = 1'b1;
            if (!inrange_ff) begin
               deny_inc = 1'b1;
               tokens   = '0;
            end else if (!known_ff) begin
               set_valid = 1'b1;
               wr_en     = 1'b1;
               grant_inc = 1'b1;
               allowed   = 1'b1;
            end else begin
               wr_en = 1'b1;
               if (grant_ok) begin
                  tokens    = debit;
                  grant_inc = 1'b1;
                  allowed   = 1'b1;
               end else begin
                  tokens   = refill_ff;
                  deny_inc = 1'b1;
               end
            end
         end
         ptb_pkg::OP_RESET: begin
            wr_en = known_ff;
         end
         default: begin
            tokens = known_ff ? rd_tokens_ff : bucket_capacity;
         end
      endcase
   end

   always_comb begin
      seen_in    = seen_ff;
      granted_in = granted_ff;
      denied_in  = denied_ff;
      active_in  = active_ff;
      if (cmd.commit) begin
         if (seen_inc && seen_ff != '1)      seen_in    = seen_ff + 1'b1;
         if (grant_inc && granted_ff != '1)  granted_in = granted_ff + 1'b1;
         if (deny_inc && denied_ff != '1)    denied_in  = denied_ff + 1'b1;
         if (set_valid)                      active_in  = active_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         seen_ff    <= '0;
         granted_ff <= '0;
         denied_ff  <= '0;
         active_ff  <= '0;
      end else begin
         if (cmd.commit && set_valid) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         seen_ff    <= seen_in;
         granted_ff <= granted_in;
         denied_ff  <= denied_in;
         active_ff  <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= {{ptb_pkg::RSP_PAD_W{1'b0}}, active_in, denied_in, granted_in,
                         seen_in, known_ff, tokens, allowed};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== hw/rtl/per_client_token_bucket.sv =====
`timescale 1ns / 1ps

// Per-client token bucket policer. Each transaction carries an op (request,
// query or bucket reset), a client index and a tick time stamp, and yields
// one result: grant flag, the client's tokens (Q16.24), whether the client
// was known, and the running request, grant, deny and active-client counts.
// One item is in flight at a time. Its steps run in order: the accepting
// edge reads the table, then come the elapsed-times-rate multiply, the
// refill with cap, and the grant decision with table write-back that loads
// the result register. A new transaction is accepted only once the last
// one has loaded the result register. The result sits in an output
// register, so the next transaction can be accepted while it waits to be
// taken; a stalled result holds the final step until it drains. The bucket
// table has one read and one write port; its valid map clears at reset,
// so no clearing pass is needed. Registers: refill_rate at 0x0,
// bucket_capacity at 0x8, write only while no transaction is in flight.

module per_client_token_bucket #(
   parameter int MAX_CLIENTS = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // client [7:0], now_ticks [39:8]
   input  logic [ptb_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op [1:0]
   input  logic [ptb_pkg::OP_W-1:0]           req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // allowed [0], tokens [40:1], client_known [41], total_count [73:42],
   // granted_count [105:74], denied_count [137:106], active_clients [146:138]
   output logic [ptb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ptb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ptb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ptb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   ptb_pkg::ctl_cmd_type        cmd;
   logic [ptb_pkg::RATE_W-1:0]  refill_rate;
   logic [ptb_pkg::TOKEN_W-1:0] bucket_capacity;

   ptb_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .refill_rate     (refill_rate),
      .bucket_capacity (bucket_capacity)
   );

   ptb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ptb_dpath #(
      .MAX_CLIENTS (MAX_CLIENTS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .refill_rate     (refill_rate),
      .bucket_capacity (bucket_capacity),
      .rsp_tdata       (rsp_tdata)
   );

endmodule

// ===== hw/rtl/ptb_checker.sv =====
`timescale 1ns / 1ps

module ptb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ptb_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic req_fire;
   assign req_fire = req_tvalid & req_tready;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one transaction in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("accepted back to back");

   // a fresh result follows an accepted transaction
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_fire, 4))
      else $error("result without matching transaction");

   // a grant is always reflected in the grant counter
   a_grant_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[105:74] != '0)
      else $error("grant with zero grant count");

endmodule

bind per_client_token_bucket ptb_checker u_ptb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam logic [ptb_pkg::OP_W-1:0]       OP_SPARE      = 2'd3;
   localparam logic [ptb_pkg::CSR_ADDR_W-1:0] CSR_RATE_ADDR = 4'h0;
   localparam logic [ptb_pkg::CSR_ADDR_W-1:0] CSR_CAP_ADDR  = 4'h8;
   localparam logic [ptb_pkg::RATE_W-1:0]     RATE_MAX      = '1;
   localparam logic [ptb_pkg::TOKEN_W-1:0]    CAP_MAX       = '1;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_SLACK     = 10;
   localparam int ITEMS_PER_PHASE = 30;
   localparam int HOLD_CYCLES     = 80;
   localparam int MAX_GAP         = 30;

   typedef struct packed {
      logic [ptb_pkg::RSP_PAD_W-1:0] pad;
      logic [ptb_pkg::ACTIVE_W-1:0]  active_clients;
      logic [ptb_pkg::COUNT_W-1:0]   denied_count;
      logic [ptb_pkg::COUNT_W-1:0]   granted_count;
      logic [ptb_pkg::COUNT_W-1:0]   total_count;
      logic                          client_known;
      logic [ptb_pkg::TOKEN_W-1:0]   tokens;
      logic                          allowed;
   } verdict_type;

   class bucket_scoreboard;
      bit                           entry_live[ptb_pkg::CLIENT_SPAN];
      logic [ptb_pkg::TOKEN_W-1:0]  entry_tok[ptb_pkg::CLIENT_SPAN];
      logic [ptb_pkg::TIME_W-1:0]   entry_when[ptb_pkg::CLIENT_SPAN];
      logic [ptb_pkg::COUNT_W-1:0]  seen;
      logic [ptb_pkg::COUNT_W-1:0]  granted;
      logic [ptb_pkg::COUNT_W-1:0]  denied;
      logic [ptb_pkg::ACTIVE_W-1:0] live_count;
      logic [ptb_pkg::RATE_W-1:0]   rate;
      logic [ptb_pkg::TOKEN_W-1:0]  capacity;
      verdict_type                  pending_verdicts[$];
      int                           errors;

      function new();
         foreach (entry_live[i]) begin
            entry_live[i] = 1'b0;
            entry_tok[i]  = '0;
            entry_when[i] = '0;
         end
         seen       = '0;
         granted    = '0;
         denied     = '0;
         live_count = '0;
         rate       = ptb_pkg::RATE_RESET;
         capacity   = ptb_pkg::CAPACITY_RESET;
         errors     = 0;
      endfunction

      function int pending();
         return pending_verdicts.size();
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      function logic [ptb_pkg::COUNT_W-1:0] bump(logic [ptb_pkg::COUNT_W-1:0] v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      function void set_reg(logic [ptb_pkg::CSR_ADDR_W-1:0] addr, logic [63:0] value);
         if (addr == CSR_RATE_ADDR) rate = value[ptb_pkg::RATE_W-1:0];
         else capacity = value[ptb_pkg::TOKEN_W-1:0];
      endfunction

      // predict the result of one accepted transaction
      function void note_accepted(logic [ptb_pkg::OP_W-1:0] op,
                                  logic [ptb_pkg::CLIENT_W-1:0] cl,
                                  logic [ptb_pkg::TIME_W-1:0] now);
         verdict_type                 v;
         logic [ptb_pkg::TOKEN_W-1:0] t;
         logic [ptb_pkg::PROD_W-1:0]  add;
         logic [ptb_pkg::TIME_W-1:0]  elapsed;
         bit                          known;
         known = entry_live[cl];
         v = '0;
         t = capacity;
         if (op == ptb_pkg::OP_REQUEST) begin
            seen = bump(seen);
            if (!known) begin
               entry_live[cl] = 1'b1;
               entry_tok[cl]  = capacity;
               entry_when[cl] = now;
               live_count     = live_count + 1'b1;
               granted        = bump(granted);
               v.allowed      = 1'b1;
               t              = capacity;
            end else begin
               elapsed = now - entry_when[cl];
               add = ptb_pkg::PROD_W'(elapsed) * ptb_pkg::PROD_W'(rate);
               if (entry_tok[cl] >= capacity ||
                   add >= ptb_pkg::PROD_W'(capacity - entry_tok[cl]))
                  t = capacity;
               else
                  t = entry_tok[cl] + add[ptb_pkg::TOKEN_W-1:0];
               entry_when[cl] = now;
               if (t >= ptb_pkg::ONE_TOKEN) begin
                  t         = t - ptb_pkg::ONE_TOKEN;
                  granted   = bump(granted);
                  v.allowed = 1'b1;
               end else begin
                  denied = bump(denied);
               end
               entry_tok[cl] = t;
            end
         end else if (op == ptb_pkg::OP_RESET) begin
            if (known) begin
               entry_tok[cl]  = capacity;
               entry_when[cl] = now;
            end
            t = capacity;
         end else begin
            t = known ? entry_tok[cl] : capacity;
         end
         v.tokens         = t;
         v.client_known   = known;
         v.total_count    = seen;
         v.granted_count  = granted;
         v.denied_count   = denied;
         v.active_clients = live_count;
         pending_verdicts.push_back(v);
      endfunction

      function void compare(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got)
            flag($sformatf("mismatch on %s: expected %0h, got %0h", name, want, got));
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            flag($sformatf("unexpected result transaction %0h", got));
            return;
         end
         want = pending_verdicts.pop_front();
         compare("allowed", 64'(want.allowed), 64'(got.allowed));
         compare("tokens", 64'(want.tokens), 64'(got.tokens));
         compare("client_known", 64'(want.client_known), 64'(got.client_known));
         compare("total_count", 64'(want.total_count), 64'(got.total_count));
         compare("granted_count", 64'(want.granted_count), 64'(got.granted_count));
         compare("denied_count", 64'(want.denied_count), 64'(got.denied_count));
         compare("active_clients", 64'(want.active_clients), 64'(got.active_clients));
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [ptb_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [ptb_pkg::OP_W-1:0]       req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [ptb_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [ptb_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [ptb_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [ptb_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   bucket_scoreboard sb = new();

   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   int cycle_count;
   logic [ptb_pkg::TIME_W-1:0] last_now[ptb_pkg::CLIENT_SPAN];

   per_client_token_bucket uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_verdict(verdict_type'(rsp_tdata));
   end

   task automatic send_item(logic [ptb_pkg::OP_W-1:0] op,
                            logic [ptb_pkg::CLIENT_W-1:0] cl,
                            logic [ptb_pkg::TIME_W-1:0] now);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {now, cl};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      sb.note_accepted(op, cl, now);
      last_now[cl] = now;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic csr_transfer(bit write, logic [ptb_pkg::CSR_ADDR_W-1:0] addr,
                               logic [63:0] wdata, output logic [63:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic program_reg(logic [ptb_pkg::CSR_ADDR_W-1:0] addr, logic [63:0] value);
      logic [63:0] mask;
      logic [63:0] rdata;
      mask = (addr == CSR_RATE_ADDR) ? 64'hFFFF_FFFF : 64'hFF_FFFF_FFFF;
      csr_transfer(1'b1, addr, value & mask, rdata);
      csr_transfer(1'b0, addr, '0, rdata);
      if ((rdata & mask) !== (value & mask))
         sb.flag($sformatf("mismatch on register %0h: expected %0h, got %0h",
                           addr, value & mask, rdata & mask));
      sb.set_reg(addr, value & mask);
   endtask

   task automatic program_bucket(logic [ptb_pkg::RATE_W-1:0] rate,
                                 logic [ptb_pkg::TOKEN_W-1:0] cap);
      program_reg(CSR_RATE_ADDR, 64'(rate));
      program_reg(CSR_CAP_ADDR, 64'(cap));
   endtask

   task automatic apply_setting(int kind);
      logic [ptb_pkg::TOKEN_W-1:0] cap;
      case (kind)
         0: begin
            cap = ptb_pkg::ONE_TOKEN * $urandom_range(1, 4)
                  + $urandom_range(0, (1 << ptb_pkg::FRAC_BITS) - 1);
            program_bucket($urandom_range(0, 1 << 22), cap);
         end
         1: program_bucket(RATE_MAX, CAP_MAX);
         2: program_bucket('0, ptb_pkg::ONE_TOKEN * $urandom_range(0, 3));
         3: program_bucket($urandom, {8'($urandom_range(0, 255)), 32'($urandom)});
         default: program_bucket(ptb_pkg::RATE_RESET, ptb_pkg::CAPACITY_RESET);
      endcase
   endtask

   initial begin
      logic [ptb_pkg::CLIENT_W-1:0] hot[4];
      logic [ptb_pkg::CLIENT_W-1:0] cl;
      logic [ptb_pkg::OP_W-1:0]     op;
      logic [ptb_pkg::TIME_W-1:0]   now;

      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      rsp_tready     = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 0;
      cycle_count    = 0;
      foreach (last_now[i]) last_now[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: unseen client ops, creation, wrap of elapsed time
      send_item(ptb_pkg::OP_QUERY, 8'd0, 32'd0);
      send_item(ptb_pkg::OP_RESET, 8'd0, 32'h10);
      send_item(OP_SPARE, 8'hFF, 32'hFFFF_FFFF);
      send_item(ptb_pkg::OP_REQUEST, 8'd0, 32'd0);
      send_item(ptb_pkg::OP_REQUEST, 8'd0, 32'd0);
      send_item(ptb_pkg::OP_QUERY, 8'd0, 32'd7);
      send_item(OP_SPARE, 8'd0, 32'd7);
      send_item(ptb_pkg::OP_REQUEST, 8'hFF, 32'hFFFF_FFFF);
      send_item(ptb_pkg::OP_REQUEST, 8'hFF, 32'd5);
      send_item(ptb_pkg::OP_RESET, 8'hFF, 32'd100);
      send_item(ptb_pkg::OP_REQUEST, 8'hFF, 32'd100);

      // no refill, one and a half tokens: grant, grant, deny
      drain();
      program_bucket('0, ptb_pkg::ONE_TOKEN + (ptb_pkg::ONE_TOKEN >> 1));
      send_item(ptb_pkg::OP_REQUEST, 8'd10, 32'd1000);
      send_item(ptb_pkg::OP_REQUEST, 8'd10, 32'd1001);
      send_item(ptb_pkg::OP_REQUEST, 8'd10, 32'd1002);
      send_item(ptb_pkg::OP_QUERY, 8'd10, 32'd1003);

      // widest rate and capacity: refill saturates
      drain();
      program_bucket(RATE_MAX, CAP_MAX);
      send_item(ptb_pkg::OP_REQUEST, 8'd10, 32'h8000_0000);
      send_item(ptb_pkg::OP_REQUEST, 8'd20, 32'd0);
      send_item(ptb_pkg::OP_QUERY, 8'd20, 32'd1);

      // capacity dropped below held tokens, then clamped on refill
      drain();
      program_bucket('0, '0);
      send_item(ptb_pkg::OP_QUERY, 8'd20, 32'd2);
      send_item(ptb_pkg::OP_REQUEST, 8'd20, 32'd3);
      send_item(ptb_pkg::OP_REQUEST, 8'd21, 32'd4);
      send_item(ptb_pkg::OP_REQUEST, 8'd21, 32'd5);
      send_item(ptb_pkg::OP_RESET, 8'd20, 32'd6);

      for (int ip = 0; ip < 4; ip++) begin
         for (int k = 0; k < 2; k++) begin
            drain();
            case (ip)
               0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
               1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
               2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
               default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            apply_setting((ip * 2 + k) % 5);
            foreach (hot[i])
               hot[i] = ptb_pkg::CLIENT_W'($urandom_range(0, ptb_pkg::CLIENT_SPAN - 1));
            if (ip == 0 && k == 0) hold_left = HOLD_CYCLES;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
               if ($urandom_range(99) < 80) begin
                  cl = hot[$urandom_range(0, 3)];
                  if ($urandom_range(99) < 75) op = ptb_pkg::OP_REQUEST;
                  else op = $urandom_range(1) ? ptb_pkg::OP_QUERY : ptb_pkg::OP_RESET;
                  if ($urandom_range(99) < 90) now = last_now[cl] + $urandom_range(0, 16);
                  else now = $urandom;
               end else begin
                  op  = ptb_pkg::OP_W'($urandom_range(0, 3));
                  cl  = ptb_pkg::CLIENT_W'($urandom_range(0, ptb_pkg::CLIENT_SPAN - 1));
                  now = $urandom;
               end
               send_item(op, cl, now);
            end
         end
      end

      // every client gets a bucket
      drain();
      send_idle_pct  = 17;
      recv_stall_pct = 17;
      apply_setting(4);
      for (int c = 0; c < ptb_pkg::CLIENT_SPAN; c++)
         send_item(ptb_pkg::OP_REQUEST, ptb_pkg::CLIENT_W'(c), $urandom);
      send_item(ptb_pkg::OP_QUERY,
                ptb_pkg::CLIENT_W'($urandom_range(0, ptb_pkg::CLIENT_SPAN - 1)), $urandom);

      drain();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
